### rtl/salc_pkg.sv
package salc_pkg;

   localparam int unsigned ADDR_W  = 64;
   localparam int unsigned STAMP_W = 64;
   localparam int unsigned CNT_W   = 32;
   localparam int unsigned SETB_W  = 3;
   localparam int unsigned BLKB_W  = 6;
   localparam int unsigned WAYSU_W = 4;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 6;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_BITS   = 2'd0,
      CSR_BLOCK_BITS = 2'd1,
      CSR_WAYS_USED  = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_FILL  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WRITE
   } state_type;

   // Shift right that yields zero at 64 or more.
   function automatic logic [ADDR_W-1:0] shift_down(input logic [ADDR_W-1:0] v,
                                                   input logic [6:0] n);
      logic [ADDR_W-1:0] r;
      begin
         r = (n >= 7'd64) ? '0 : (v >> n[5:0]);
         return r;
      end
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      begin
         return (v == COUNT_MAX) ? v : v + 1'b1;
      end
   endfunction

endpackage

### rtl/set_assoc_lru_cache_sim_top.sv
// Set-associative cache model with LRU replacement. Each request carries a
// byte address; one response per request gives hit, fill or eviction, the way
// used and the three saturating totals. After reset the valid store is swept
// clear, one set per cycle, before the back end takes the first queued request.
// Each access in the back end is a single read-modify-write of the set row
// (queue pop, set row read, compare and write back); the front end queues up
// to two addresses meanwhile. The user must write the configuration registers
// through the csr_ port only while idle; the block itself does not enforce it.
module set_assoc_lru_cache_sim_top #(
   parameter int unsigned MAX_SET_BITS = 6,
   parameter int unsigned MAX_WAYS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [salc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [salc_pkg::CSR_DAT_W-1:0]    csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [salc_pkg::ADDR_W-1:0]       req_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_outcome,
   output logic [2:0]                        rsp_way_used,
   output logic [salc_pkg::CNT_W-1:0]        rsp_hit_total,
   output logic [salc_pkg::CNT_W-1:0]        rsp_miss_total,
   output logic [salc_pkg::CNT_W-1:0]        rsp_eviction_total
);

   localparam int unsigned SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

   logic [salc_pkg::SETB_W-1:0]  set_bits_ff;
   logic [salc_pkg::BLKB_W-1:0]  block_bits_ff;
   logic [salc_pkg::WAYSU_W-1:0] ways_used_ff;
   logic                         q_valid, q_ready;
   logic [SET_W-1:0]             q_set;
   logic [salc_pkg::ADDR_W-1:0]  q_tag;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 3'd4;
         block_bits_ff <= 6'd4;
         ways_used_ff  <= 4'd1;
      end else if (csr_valid) begin
         unique case (salc_pkg::csr_idx_type'(csr_index))
            salc_pkg::CSR_SET_BITS:   set_bits_ff   <= csr_data[2:0];
            salc_pkg::CSR_BLOCK_BITS: block_bits_ff <= csr_data;
            salc_pkg::CSR_WAYS_USED:  ways_used_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   salc_front #(.MAX_SET_BITS(MAX_SET_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_address (req_address),
      .set_bits    (set_bits_ff),
      .block_bits  (block_bits_ff),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_set       (q_set),
      .q_tag       (q_tag)
   );

   salc_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .ways_used          (ways_used_ff),
      .q_valid            (q_valid),
      .q_ready            (q_ready),
      .q_set              (q_set),
      .q_tag              (q_tag),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_outcome        (rsp_outcome),
      .rsp_way_used       (rsp_way_used),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total)
   );

endmodule

### rtl/salc_front.sv
// Front end: accept an address, split it into set index and tag, queue it.
module salc_front #(
   parameter int unsigned MAX_SET_BITS = 6,
   parameter int unsigned SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [salc_pkg::ADDR_W-1:0]   req_address,
   input  logic [salc_pkg::SETB_W-1:0]   set_bits,
   input  logic [salc_pkg::BLKB_W-1:0]   block_bits,
   output logic                          q_valid,
   input  logic                          q_ready,
   output logic [SET_W-1:0]              q_set,
   output logic [salc_pkg::ADDR_W-1:0]   q_tag
);

   localparam int unsigned DEPTH = 2;

   logic [1:0]                        cnt_ff, cnt_in;
   logic                              wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [SET_W-1:0]                  set_ff [DEPTH];
   logic [salc_pkg::ADDR_W-1:0]       tag_ff [DEPTH];
   logic [2:0]                        sb;
   logic [salc_pkg::ADDR_W-1:0]       shifted;
   logic [salc_pkg::ADDR_W-1:0]       idx_mask;
   logic [SET_W-1:0]                  set_idx;
   logic [salc_pkg::ADDR_W-1:0]       tag;
   logic                              push, pop;

   // Clamp set bits and split the address
   always_comb begin
      sb = (32'(set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits;
      shifted  = salc_pkg::shift_down(req_address, {1'b0, block_bits});
      idx_mask = (64'd1 << sb) - 64'd1;
      set_idx  = SET_W'(shifted & idx_mask);
      tag      = salc_pkg::shift_down(req_address, 7'(sb) + 7'(block_bits));
   end

   assign req_ready = (cnt_ff != 2'(DEPTH));
   assign push = req_valid && req_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_set = set_ff[rptr_ff];
   assign q_tag = tag_ff[rptr_ff];

   always_comb begin
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
   end

   // Advance queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
   end

   // Hold queued payload
   always_ff @(posedge clock) begin
      if (push) begin
         set_ff[wptr_ff] <= set_idx;
         tag_ff[wptr_ff] <= tag;
      end
   end

endmodule

### rtl/salc_back.sv
// Back end: read the set, compare the ways in use, write back the chosen way.
module salc_back #(
   parameter int unsigned MAX_SET_BITS = 6,
   parameter int unsigned MAX_WAYS = 8,
   parameter int unsigned SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
   parameter int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [salc_pkg::WAYSU_W-1:0]  ways_used,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  logic [SET_W-1:0]              q_set,
   input  logic [salc_pkg::ADDR_W-1:0]   q_tag,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_outcome,
   output logic [2:0]                    rsp_way_used,
   output logic [salc_pkg::CNT_W-1:0]    rsp_hit_total,
   output logic [salc_pkg::CNT_W-1:0]    rsp_miss_total,
   output logic [salc_pkg::CNT_W-1:0]    rsp_eviction_total
);

   localparam int unsigned SETS = 1 << MAX_SET_BITS;

   typedef logic [salc_pkg::ADDR_W-1:0]  tag_row_type   [MAX_WAYS];
   typedef logic [salc_pkg::STAMP_W-1:0] stamp_row_type [MAX_WAYS];

   salc_pkg::state_type state_ff, state_in;

   // One memory row per set, all ways side by side
   logic [salc_pkg::ADDR_W-1:0]  tag_mem   [SETS][MAX_WAYS];
   logic [salc_pkg::STAMP_W-1:0] stamp_mem [SETS][MAX_WAYS];
   logic [MAX_WAYS-1:0]          valid_mem [SETS];

   tag_row_type             tag_rd_ff;
   stamp_row_type           stamp_rd_ff;
   logic [MAX_WAYS-1:0]     valid_rd_ff;
   logic [SET_W-1:0]        clr_ff, clr_in;
   logic [SET_W-1:0]        set_ff, set_in;
   logic [salc_pkg::ADDR_W-1:0] tag_ff, tag_in;
   logic [salc_pkg::STAMP_W-1:0] clock_ff, clock_in;
   logic [salc_pkg::CNT_W-1:0] hit_ff, hit_in, miss_ff, miss_in, evict_ff, evict_in;
   logic                    out_valid_ff, out_valid_in;
   logic [1:0]              outcome_ff, outcome_in;
   logic [2:0]              way_out_ff, way_out_in;

   logic [4:0]              ways;
   logic                    hit;
   logic [WAY_W-1:0]        hit_way;
   logic                    have_empty;
   logic [WAY_W-1:0]        empty_way;
   logic [WAY_W-1:0]        victim;
   logic [salc_pkg::STAMP_W-1:0] oldest;
   logic [WAY_W-1:0]        chosen;
   logic                    do_write;
   logic                    fill;

   // Search the ways in use of the read row
   always_comb begin
      ways = {1'b0, ways_used};
      if (ways == 5'd0) begin
         ways = 5'd1;
      end
      if (32'(ways) > MAX_WAYS) begin
         ways = 5'(MAX_WAYS);
      end
      hit = 1'b0;
      hit_way = '0;
      have_empty = 1'b0;
      empty_way = '0;
      victim = '0;
      oldest = '1;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (w < 32'(ways)) begin
            if (valid_rd_ff[w] && tag_rd_ff[w] == tag_ff) begin
               hit = 1'b1;
               hit_way = WAY_W'(w);
            end
            if (!valid_rd_ff[w]) begin
               have_empty = 1'b1;
               empty_way = WAY_W'(w);
            end
         end
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (w < 32'(ways) && valid_rd_ff[w] && stamp_rd_ff[w] < oldest) begin
            oldest = stamp_rd_ff[w];
            victim = WAY_W'(w);
         end
      end
      chosen = hit ? hit_way : (have_empty ? empty_way : victim);
   end

   // Sequencer: clear sweep, idle, read row, compare and write
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      clock_in     = clock_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      evict_in     = evict_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      outcome_in   = outcome_ff;
      way_out_in   = way_out_ff;
      q_ready      = 1'b0;
      do_write     = 1'b0;
      fill         = 1'b0;
      unique case (state_ff)
         salc_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == SETS - 1) begin
               state_in = salc_pkg::ST_IDLE;
            end
         end
         salc_pkg::ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               set_in   = q_set;
               tag_in   = q_tag;
               state_in = salc_pkg::ST_READ;
            end
         end
         salc_pkg::ST_READ: begin
            state_in = salc_pkg::ST_WRITE;
         end
         salc_pkg::ST_WRITE: begin
            if (!out_valid_ff || rsp_ready) begin
               do_write     = 1'b1;
               fill         = !hit;
               out_valid_in = 1'b1;
               way_out_in   = 3'(chosen);
               clock_in     = clock_ff + 1'b1;
               if (hit) begin
                  outcome_in = salc_pkg::OUT_HIT;
                  hit_in = salc_pkg::sat_inc(hit_ff);
               end else begin
                  miss_in = salc_pkg::sat_inc(miss_ff);
                  if (have_empty) begin
                     outcome_in = salc_pkg::OUT_FILL;
                  end else begin
                     outcome_in = salc_pkg::OUT_EVICT;
                     evict_in = salc_pkg::sat_inc(evict_ff);
                  end
               end
               state_in = salc_pkg::ST_IDLE;
            end
         end
         default: state_in = salc_pkg::ST_IDLE;
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         clock_ff     <= 64'd1;
         hit_ff       <= '0;
         miss_ff      <= '0;
         evict_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clock_ff     <= clock_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         evict_ff     <= evict_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      set_ff     <= set_in;
      tag_ff     <= tag_in;
      outcome_ff <= outcome_in;
      way_out_ff <= way_out_in;
   end

   // Row read, registered
   always_ff @(posedge clock) begin
      tag_rd_ff   <= tag_mem[set_ff];
      stamp_rd_ff <= stamp_mem[set_ff];
      valid_rd_ff <= valid_mem[set_ff];
   end

   // Valid store: clear sweep after reset, set on fill
   always_ff @(posedge clock) begin
      if (state_ff == salc_pkg::ST_CLEAR) begin
         valid_mem[clr_ff] <= '0;
      end else if (fill) begin
         valid_mem[set_ff] <= valid_rd_ff | (MAX_WAYS'(1) << chosen);
      end
   end

   // Tag and stamp write of the chosen way
   always_ff @(posedge clock) begin
      if (do_write) begin
         stamp_mem[set_ff][chosen] <= clock_ff;
         if (fill) begin
            tag_mem[set_ff][chosen] <= tag_ff;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_outcome        = outcome_ff;
   assign rsp_way_used       = way_out_ff;
   assign rsp_hit_total      = hit_ff;
   assign rsp_miss_total     = miss_ff;
   assign rsp_eviction_total = evict_ff;

endmodule
